// File: rtl/flpw_pkg.sv
// Shared types, constants and microcode program of the four-level page walk.
package flpw_pkg;

  // Default number of page-table frames in the local store.
  localparam int unsigned STORE_FRAMES_DEF = 16;

  // Table geometry: 512 entries per table, 9 index bits per level.
  localparam int unsigned IDX_BITS          = 9;
  localparam int unsigned ENTRIES_PER_TABLE = 1 << IDX_BITS;
  localparam int unsigned IDX_MASK          = (1 << IDX_BITS) - 1;
  localparam int unsigned PAGE_SHIFT        = 12;
  localparam int unsigned WALK_LEVELS       = 4;
  localparam logic [1:0]  TOP_LEVEL         = 2'(WALK_LEVELS - 1);

  // Field widths.
  localparam int unsigned VA_W    = 48;
  localparam int unsigned PA_W    = 52;
  localparam int unsigned PTE_W   = 64;
  localparam int unsigned EIDX_W  = 13;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned ROOT_W  = 4;
  localparam int unsigned CFG_W   = 48;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned PFN_W   = PA_W - PAGE_SHIFT;

  // Entry bit positions.
  localparam int unsigned PTE_PRESENT = 0;
  localparam int unsigned PTE_USER    = 2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_ROOT_FRAME = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_VA_LOW     = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_VA_HIGH    = 2'd2;

  // Configuration reset values.
  localparam logic [ROOT_W-1:0] ROOT_RESET    = '0;
  localparam logic [VA_W-1:0]   VA_LOW_RESET  = 48'h0000_0000_1000;
  localparam logic [VA_W-1:0]   VA_HIGH_RESET = 48'h8000_0000_0000;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_WINDOW      = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_PRESENT = 3'd2;
  localparam logic [STAT_W-1:0] ST_USER        = 3'd3;
  localparam logic [STAT_W-1:0] ST_OUTSIDE     = 3'd4;

  // Input function codes.
  localparam logic FUNC_WRITE     = 1'b0;
  localparam logic FUNC_TRANSLATE = 1'b1;

  // Microcode step addresses.
  localparam int unsigned PC_W = 2;
  localparam logic [PC_W-1:0] STEP_IDLE   = 2'd0;
  localparam logic [PC_W-1:0] STEP_WALK   = 2'd1;
  localparam logic [PC_W-1:0] STEP_FINISH = 2'd2;

  typedef enum logic [1:0] {
    ACT_NOP    = 2'd0,
    ACT_ACCEPT = 2'd1,
    ACT_WALK   = 2'd2,
    ACT_EMIT   = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    COND_ALWAYS   = 2'd0,
    COND_IN_VALID = 2'd1,
    COND_MORE     = 2'd2,
    COND_OUT_FREE = 2'd3
  } cond_e;

  // One control word: datapath action, jump condition and target, and
  // whether a failed condition holds the step instead of advancing.
  typedef struct packed {
    act_e            act;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            stay;
  } ucode_t;

  // Jump conditions gathered from the request input, the datapath and the output side.
  typedef struct packed {
    logic in_valid;
    logic more;
    logic out_free;
  } seq_cond_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root_frame;
    logic [VA_W-1:0]   va_low;
    logic [VA_W-1:0]   va_high;
  } cfg_t;

  // Microcode program.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      STEP_IDLE:   w = '{act: ACT_ACCEPT, cond: COND_IN_VALID, target: STEP_WALK, stay: 1'b1};
      STEP_WALK:   w = '{act: ACT_WALK, cond: COND_MORE, target: STEP_WALK, stay: 1'b0};
      STEP_FINISH: w = '{act: ACT_EMIT, cond: COND_OUT_FREE, target: STEP_IDLE, stay: 1'b1};
      default:     w = '{act: ACT_NOP, cond: COND_ALWAYS, target: STEP_IDLE, stay: 1'b0};
    endcase
    return w;
  endfunction

  // Table index bits of a virtual address for one level.
  function automatic logic [IDX_BITS-1:0] va_slot(input logic [VA_W-1:0] va,
                                                  input logic [1:0] lvl);
    logic [IDX_BITS-1:0] s;
    case (lvl)
      2'd0:    s = va[PAGE_SHIFT                +: IDX_BITS];
      2'd1:    s = va[PAGE_SHIFT + IDX_BITS     +: IDX_BITS];
      2'd2:    s = va[PAGE_SHIFT + 2 * IDX_BITS +: IDX_BITS];
      default: s = va[PAGE_SHIFT + 3 * IDX_BITS +: IDX_BITS];
    endcase
    return s;
  endfunction

endpackage

// File: rtl/flpw_ram.sv
// Generic single-port RAM with registered read data.
module flpw_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/flpw_seq.sv
// Microcode sequencer: step counter, control-word table and conditional jumps.
module flpw_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  flpw_pkg::seq_cond_t cond_i,
  output flpw_pkg::ucode_t    ctrl_o
);

  logic [flpw_pkg::PC_W-1:0] pc_q, pc_d;
  flpw_pkg::ucode_t          word;
  logic                      taken;

  assign word = flpw_pkg::ucode_rom(pc_q);

  always_comb begin
    case (word.cond)
      flpw_pkg::COND_ALWAYS:   taken = 1'b1;
      flpw_pkg::COND_IN_VALID: taken = cond_i.in_valid;
      flpw_pkg::COND_MORE:     taken = cond_i.more;
      flpw_pkg::COND_OUT_FREE: taken = cond_i.out_free;
      default:                 taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      pc_d = word.target;
    end else if (word.stay) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= flpw_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = word;

endmodule

// File: rtl/flpw_dp.sv
// Walk datapath: request latch, table store, per-level entry checks.
module flpw_dp #(
  parameter int unsigned STORE_FRAMES = flpw_pkg::STORE_FRAMES_DEF
) (
  input  logic                              clk_i,
  input  flpw_pkg::ucode_t                  ctrl_i,
  input  flpw_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  input  logic                              func_i,
  input  logic [flpw_pkg::EIDX_W-1:0]       entry_index_i,
  input  logic [flpw_pkg::PTE_W-1:0]        entry_value_i,
  input  logic [flpw_pkg::VA_W-1:0]         virt_addr_i,
  input  logic                              user_mode_i,
  output logic                              more_o,
  output logic [flpw_pkg::PA_W-1:0]         phys_addr_o,
  output logic [flpw_pkg::STAT_W-1:0]       status_o
);

  localparam int unsigned Depth  = STORE_FRAMES * flpw_pkg::ENTRIES_PER_TABLE;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned FrameW = (STORE_FRAMES > 1) ? $clog2(STORE_FRAMES) : 1;
  localparam int unsigned FullW  = FrameW + flpw_pkg::IDX_BITS;

  logic [flpw_pkg::VA_W-1:0]   va_q;
  logic                        user_q;
  logic                        walk_q;
  logic [1:0]                  lvl_q;
  logic [flpw_pkg::STAT_W-1:0] status_q;
  logic [flpw_pkg::PA_W-1:0]   phys_q;

  logic                        accept;
  logic                        active;
  logic [flpw_pkg::STAT_W-1:0] prefault;
  logic                        write_ok;
  logic [31:0]                 widx;
  logic [31:0]                 root_ext;
  logic [FullW-1:0]            full_addr;
  logic [AddrW-1:0]            ram_addr;
  logic                        ram_we;
  logic [flpw_pkg::PTE_W-1:0]  ram_rdata;
  logic [flpw_pkg::PTE_W-1:0]  entry;
  logic                        present;
  logic [flpw_pkg::PFN_W-1:0]  next_pfn;
  logic                        next_oob;
  logic [1:0]                  lvl_dn;

  assign accept   = in_valid_i && (ctrl_i.act == flpw_pkg::ACT_ACCEPT);
  assign active   = (ctrl_i.act == flpw_pkg::ACT_WALK) && walk_q &&
                    (status_q == flpw_pkg::ST_OK);

  assign widx     = 32'(entry_index_i);
  assign root_ext = 32'(cfg_i.root_frame);
  assign write_ok = widx < Depth;

  always_comb begin
    if (virt_addr_i < cfg_i.va_low || virt_addr_i >= cfg_i.va_high) begin
      prefault = flpw_pkg::ST_WINDOW;
    end else if (root_ext >= STORE_FRAMES) begin
      prefault = flpw_pkg::ST_OUTSIDE;
    end else begin
      prefault = flpw_pkg::ST_OK;
    end
  end

  assign entry    = ram_rdata;
  assign present  = entry[flpw_pkg::PTE_PRESENT];
  assign next_pfn = entry[flpw_pkg::PA_W-1:flpw_pkg::PAGE_SHIFT];
  assign next_oob = next_pfn >= flpw_pkg::PFN_W'(STORE_FRAMES);
  assign lvl_dn   = lvl_q - 2'd1;
  assign more_o   = active && (lvl_q != 2'd0) && present && !next_oob;

  // Address: write index or root table on accept, next table from the entry just read.
  always_comb begin
    if (accept && func_i == flpw_pkg::FUNC_WRITE) begin
      full_addr = widx[FullW-1:0];
    end else if (accept) begin
      full_addr = {root_ext[FrameW-1:0],
                   flpw_pkg::va_slot(virt_addr_i, flpw_pkg::TOP_LEVEL)};
    end else begin
      full_addr = {next_pfn[FrameW-1:0], flpw_pkg::va_slot(va_q, lvl_dn)};
    end
  end

  assign ram_addr = full_addr[AddrW-1:0];
  assign ram_we   = accept && (func_i == flpw_pkg::FUNC_WRITE) && write_ok;

  flpw_ram #(
    .Width (flpw_pkg::PTE_W),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (entry_value_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      va_q     <= virt_addr_i;
      user_q   <= user_mode_i;
      walk_q   <= func_i;
      lvl_q    <= flpw_pkg::TOP_LEVEL;
      phys_q   <= '0;
      status_q <= (func_i == flpw_pkg::FUNC_TRANSLATE) ? prefault : flpw_pkg::ST_OK;
    end else if (active) begin
      if (!present) begin
        status_q <= flpw_pkg::ST_NOT_PRESENT;
      end else if (lvl_q != 2'd0) begin
        if (next_oob) begin
          status_q <= flpw_pkg::ST_OUTSIDE;
        end else begin
          lvl_q <= lvl_dn;
        end
      end else if (entry[flpw_pkg::PTE_USER] != user_q) begin
        status_q <= flpw_pkg::ST_USER;
      end else begin
        phys_q <= {next_pfn, {flpw_pkg::PAGE_SHIFT{1'b0}}};
      end
    end
  end

  assign phys_addr_o = phys_q;
  assign status_o    = status_q;

endmodule

// File: rtl/four_level_page_walk_top.sv
// Top level of the four-level page walk: configuration, sequencer, datapath, result register.
//
// Each request is either a table-entry write or a translation. A write passes
// through accept with the store write, one pass step and result load. A
// translation walks four table levels from the root frame; every level is one
// registered read of the single-port table store whose address comes from the
// entry read before it: accept (root table read issued), four level steps,
// result load. A window or root fault takes a write's steps; a missing or
// out-of-store entry ends the walk at that level. The result sits in an output
// register, so the next request is taken while a result still waits. The user
// must write configuration only while idle; the block does not enforce it.
module four_level_page_walk_top #(
  parameter int unsigned STORE_FRAMES = flpw_pkg::STORE_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [flpw_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [flpw_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [flpw_pkg::EIDX_W-1:0]   entry_index_i,
  input  logic [flpw_pkg::PTE_W-1:0]    entry_value_i,
  input  logic [flpw_pkg::VA_W-1:0]     virt_addr_i,
  input  logic                          user_mode_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [flpw_pkg::PA_W-1:0]     phys_addr_o,
  output logic [flpw_pkg::STAT_W-1:0]   status_o
);

  flpw_pkg::cfg_t              cfg_q;
  flpw_pkg::ucode_t            ctrl;
  flpw_pkg::seq_cond_t         cond;
  logic                        more;
  logic [flpw_pkg::PA_W-1:0]   res_phys;
  logic [flpw_pkg::STAT_W-1:0] res_status;
  logic                        out_free;
  logic                        emit;

  logic                        out_valid_q;
  logic [flpw_pkg::PA_W-1:0]   out_phys_q;
  logic [flpw_pkg::STAT_W-1:0] out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.root_frame <= flpw_pkg::ROOT_RESET;
      cfg_q.va_low     <= flpw_pkg::VA_LOW_RESET;
      cfg_q.va_high    <= flpw_pkg::VA_HIGH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        flpw_pkg::CFG_ROOT_FRAME: cfg_q.root_frame <= cfg_data_i[flpw_pkg::ROOT_W-1:0];
        flpw_pkg::CFG_VA_LOW:     cfg_q.va_low     <= cfg_data_i[flpw_pkg::VA_W-1:0];
        flpw_pkg::CFG_VA_HIGH:    cfg_q.va_high    <= cfg_data_i[flpw_pkg::VA_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free      = !out_valid_q || !out_stall_i;
  assign cond.in_valid = in_valid_i;
  assign cond.more     = more;
  assign cond.out_free = out_free;

  flpw_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctrl_o (ctrl)
  );

  flpw_dp #(
    .STORE_FRAMES (STORE_FRAMES)
  ) u_dp (
    .clk_i         (clk_i),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .func_i        (func_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .virt_addr_i   (virt_addr_i),
    .user_mode_i   (user_mode_i),
    .more_o        (more),
    .phys_addr_o   (res_phys),
    .status_o      (res_status)
  );

  assign in_stall_o = (ctrl.act != flpw_pkg::ACT_ACCEPT);
  assign emit       = (ctrl.act == flpw_pkg::ACT_EMIT) && out_free;

  // Load a finished result, drop the held one once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_phys_q   <= res_phys;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign phys_addr_o = out_phys_q;
  assign status_o    = out_status_q;

endmodule

// File: tb/tb.sv
// Self-checking testbench of the four-level page walk: table loads, translations, window setups.
`timescale 1ns / 1ps

module tb;
  import flpw_pkg::*;

  localparam int unsigned STORE_FRAMES  = STORE_FRAMES_DEF;
  localparam int unsigned STORE_DEPTH   = STORE_FRAMES * ENTRIES_PER_TABLE;
  localparam int          LONG_HOLD     = 400;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          POOL_SIZE     = 24;

  typedef struct {
    logic              func;
    logic [EIDX_W-1:0] eidx;
    logic [PTE_W-1:0]  evalue;
    logic [VA_W-1:0]   va;
    logic              user;
  } walk_req_t;

  typedef struct {
    logic [PA_W-1:0]   phys;
    logic [STAT_W-1:0] status;
  } walk_res_t;

  // Shadow page tables plus window registers; holds the results still owed.
  class walk_scoreboard;
    logic [PTE_W-1:0]  tables [STORE_DEPTH];
    bit                loaded [STORE_DEPTH];
    int                loaded_idx [$];
    logic [ROOT_W-1:0] root_frame;
    logic [VA_W-1:0]   va_low;
    logic [VA_W-1:0]   va_high;
    walk_res_t         owed_q [$];
    int                errors;

    function new();
      root_frame = ROOT_RESET;
      va_low     = VA_LOW_RESET;
      va_high    = VA_HIGH_RESET;
      errors     = 0;
    endfunction

    function void set_config(logic [ROOT_W-1:0] rf, logic [VA_W-1:0] lo, logic [VA_W-1:0] hi);
      root_frame = rf;
      va_low     = lo;
      va_high    = hi;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Walk the shadow tables; flag the first entry on the path that was never loaded.
    function void walk(input logic [VA_W-1:0] va, input logic user, output walk_res_t res,
                       output bit hole, output int hole_idx);
      logic [PFN_W-1:0] frame;
      logic [PTE_W-1:0] e;
      int idx;
      int lvl;
      res.phys   = '0;
      res.status = ST_OK;
      hole       = 1'b0;
      hole_idx   = 0;
      if (va < va_low || va >= va_high) begin
        res.status = ST_WINDOW;
        return;
      end
      frame = PFN_W'(root_frame);
      if (frame >= STORE_FRAMES) begin
        res.status = ST_OUTSIDE;
        return;
      end
      for (lvl = WALK_LEVELS - 1; lvl >= 0; lvl--) begin
        idx = int'(frame) * ENTRIES_PER_TABLE + int'(va[PAGE_SHIFT + lvl * IDX_BITS +: IDX_BITS]);
        if (!loaded[idx]) begin
          hole     = 1'b1;
          hole_idx = idx;
          return;
        end
        e = tables[idx];
        if (!e[PTE_PRESENT]) begin
          res.status = ST_NOT_PRESENT;
          return;
        end
        if (lvl == 0) begin
          if (e[PTE_USER] != user) res.status = ST_USER;
          else res.phys = {e[PA_W-1:PAGE_SHIFT], 12'b0};
          return;
        end
        frame = e[PA_W-1:PAGE_SHIFT];
        if (frame >= STORE_FRAMES) begin
          res.status = ST_OUTSIDE;
          return;
        end
      end
    endfunction

    function void note_request(walk_req_t r);
      walk_res_t res;
      bit hole;
      int hole_idx;
      if (r.func == FUNC_WRITE) begin
        res.phys   = '0;
        res.status = ST_OK;
        if (r.eidx < STORE_DEPTH) begin
          tables[r.eidx] = r.evalue;
          if (!loaded[r.eidx]) loaded_idx.push_back(int'(r.eidx));
          loaded[r.eidx] = 1'b1;
        end
      end else begin
        walk(r.va, r.user, res, hole, hole_idx);
      end
      owed_q.push_back(res);
    endfunction

    function void check_result(logic [PA_W-1:0] phys, logic [STAT_W-1:0] status);
      walk_res_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected result: phys_addr %h status %0d", phys, status);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (phys !== want.phys) begin
        $error("phys_addr mismatch: expected %h, got %h", want.phys, phys);
        errors++;
      end
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CIDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]  cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              func_i;
  logic [EIDX_W-1:0] entry_index_i;
  logic [PTE_W-1:0]  entry_value_i;
  logic [VA_W-1:0]   virt_addr_i;
  logic              user_mode_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [PA_W-1:0]   phys_addr_o;
  logic [STAT_W-1:0] status_o;

  walk_scoreboard  sb = new();
  logic [VA_W-1:0] va_pool [$];
  int              send_idle_pct = 21;
  int              recv_idle_pct = 73;
  bit              hold_req = 1'b0;
  int              hold_left = 0;

  four_level_page_walk_top #(
    .STORE_FRAMES(STORE_FRAMES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .virt_addr_i   (virt_addr_i),
    .user_mode_i   (user_mode_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .phys_addr_o   (phys_addr_o),
    .status_o      (status_o)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stall, or a long hold when asked.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) sb.check_result(phys_addr_o, status_o);
  end

  // Entered at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input walk_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= r.func;
    entry_index_i <= r.eidx;
    entry_value_i <= r.evalue;
    virt_addr_i   <= r.va;
    user_mode_i   <= r.user;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  function automatic walk_req_t random_fields();
    walk_req_t r;
    r.func   = 1'($urandom);
    r.eidx   = EIDX_W'($urandom);
    r.evalue = {$urandom, $urandom};
    r.va     = VA_W'({$urandom, $urandom});
    r.user   = 1'($urandom);
    return r;
  endfunction

  task automatic send_write(input logic [EIDX_W-1:0] idx, input logic [PTE_W-1:0] val);
    walk_req_t r;
    r        = random_fields();
    r.func   = FUNC_WRITE;
    r.eidx   = idx;
    r.evalue = val;
    send_request(r);
  endtask

  task automatic send_translate(input logic [VA_W-1:0] va, input logic user);
    walk_req_t r;
    r      = random_fields();
    r.func = FUNC_TRANSLATE;
    r.va   = va;
    r.user = user;
    send_request(r);
  endtask

  // Mostly present entries pointing inside the store.
  function automatic logic [PTE_W-1:0] table_entry();
    logic [PTE_W-1:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(9) != 0) v[PA_W-1:PAGE_SHIFT] = PFN_W'($urandom_range(STORE_FRAMES - 1));
    v[PTE_PRESENT] = ($urandom_range(11) != 0);
    return v;
  endfunction

  function automatic logic [VA_W-1:0] window_va();
    logic [63:0] span;
    logic [63:0] pick;
    span = {16'b0, sb.va_high} - {16'b0, sb.va_low};
    pick = {$urandom, $urandom};
    if (sb.va_high > sb.va_low) return sb.va_low + VA_W'(pick % span);
    return VA_W'(pick);
  endfunction

  function automatic void remember_va(logic [VA_W-1:0] va);
    if (va_pool.size() < POOL_SIZE) va_pool.push_back(va);
    else va_pool[$urandom_range(POOL_SIZE - 1)] = va;
  endfunction

  // Favor addresses already seen so that their table paths fill in and walk deep.
  function automatic logic [VA_W-1:0] pick_va();
    logic [VA_W-1:0] va;
    int k;
    k = $urandom_range(99);
    if (k < 50 && va_pool.size() > 0) begin
      va = va_pool[$urandom_range(va_pool.size() - 1)];
      va[PAGE_SHIFT-1:0] = 12'($urandom);
    end else if (k < 65 && va_pool.size() > 0) begin
      va = va_pool[$urandom_range(va_pool.size() - 1)];
      va[PAGE_SHIFT +: 2 * IDX_BITS] = 18'($urandom);
      remember_va(va);
    end else if (k < 85) begin
      va = window_va();
      remember_va(va);
    end else if (k < 93) begin
      va = VA_W'({$urandom, $urandom});
    end else begin
      case ($urandom_range(3))
        0:       va = sb.va_low;
        1:       va = sb.va_low - 1'b1;
        2:       va = sb.va_high - 1'b1;
        default: va = sb.va_high;
      endcase
    end
    return va;
  endfunction

  function automatic walk_req_t next_request();
    walk_req_t r;
    walk_res_t res;
    bit hole;
    int hole_idx;
    r = random_fields();
    if ($urandom_range(99) < 25) begin
      r.func = FUNC_WRITE;
      if ($urandom_range(1) == 0 && sb.loaded_idx.size() > 0)
        r.eidx = EIDX_W'(sb.loaded_idx[$urandom_range(sb.loaded_idx.size() - 1)]);
      if ($urandom_range(9) < 6) r.evalue = table_entry();
    end else begin
      r.func = FUNC_TRANSLATE;
      r.va   = pick_va();
      sb.walk(r.va, r.user, res, hole, hole_idx);
      // Load the missing entry first; the same address comes back later.
      if (hole) begin
        r.func   = FUNC_WRITE;
        r.eidx   = EIDX_W'(hole_idx);
        r.evalue = table_entry();
      end
    end
    return r;
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_window(input logic [ROOT_W-1:0] rf, input logic [VA_W-1:0] lo,
                            input logic [VA_W-1:0] hi);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ROOT_FRAME;
    cfg_data_i  <= {(CFG_W - ROOT_W)'({$urandom, $urandom}), rf};
    @(negedge clk_i);
    cfg_index_i <= CFG_VA_LOW;
    cfg_data_i  <= lo;
    @(negedge clk_i);
    cfg_index_i <= CFG_VA_HIGH;
    cfg_data_i  <= hi;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_config(rf, lo, hi);
  endtask

  initial begin
    int phase_items [9];
    logic [ROOT_W-1:0] rf;
    logic [VA_W-1:0] lo;
    logic [VA_W-1:0] hi;
    phase_items = '{300, 30, 250, 280, 30, 30, 250, 250, 230};
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_ROOT_FRAME;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    func_i        = FUNC_WRITE;
    entry_index_i = '0;
    entry_value_i = '0;
    virt_addr_i   = '0;
    user_mode_i   = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: window edges, each fault kind, leaf extremes, huge-page bit ignored.
    send_write(13'd0, '1);
    send_translate(48'd0, 1'b0);
    send_translate(48'd4095, 1'b1);
    send_translate(48'h8000_0000_0000, 1'b0);
    send_translate('1, 1'b1);
    send_translate(48'h1000, 1'b0);
    send_write(13'd0, 64'h1001);
    send_write(13'd512, 64'h0);
    send_translate(48'h1000, 1'b1);
    send_write(13'd512, 64'h2001);
    send_write(13'd1024, 64'h3087);
    send_write(13'd1537, '1);
    send_translate(48'h1000, 1'b1);
    send_translate(48'h1FFF, 1'b0);
    send_write(13'd1537, 64'h1);
    send_translate(48'h1000, 1'b0);
    send_translate(48'h1000, 1'b1);
    send_write(13'd1537, 64'hFFFF_FFFF_FFFF_FFFE);
    send_translate(48'h1ABC, 1'b0);
    send_write(13'd8191, '1);
    send_write(13'd8191, 64'h0);
    send_write(13'd1024, 64'h0000_0001_0000_1001);
    send_translate(48'h1000, 1'b1);

    for (int p = 0; p < 9; p++) begin
      drain();
      rf = ROOT_W'($urandom);
      case (p)
        0, 7: begin
          lo = '0;
          hi = '1;
          if (p == 0) rf = '0;
        end
        1: begin
          lo = window_va();
          hi = lo;
        end
        2: begin
          rf = '1;
          lo = VA_LOW_RESET;
          hi = VA_HIGH_RESET;
        end
        4: begin
          lo = VA_W'({$urandom, $urandom}) | 48'd1;
          hi = '0;
        end
        5: begin
          rf = '1;
          lo = '1;
          hi = '1;
        end
        default: begin
          lo = VA_W'($urandom_range(1 << 20));
          hi = lo + VA_W'({$urandom, $urandom});
        end
      endcase
      if (p < 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 73;
      end else if (p < 7) begin
        send_idle_pct = 73;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_window(rf, lo, hi);
      // Back up the result side while requests keep coming.
      if (p == 7) hold_req = 1'b1;
      repeat (phase_items[p]) send_request(next_request());
    end
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
